// ----- rtl/i64fmt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the int64 decimal text formatter.
package i64fmt_pkg;

	localparam int VALUE_W    = 64;
	localparam int NUM_DIGITS = 19;  // 2^63 has 19 decimal digits
	localparam int DIGIT_W    = 4;
	localparam int BYTE_W     = 8;
	localparam int COL_W      = 8;

	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

	localparam logic [COL_W-1:0] COLS_RESET = 8'd5;

	// Control broadcast to every digit cell.
	typedef struct packed {
		logic clear;        // load zero at start of a conversion
		logic bit_shift;    // add-3 correction then shift in one binary bit
		logic digit_shift;  // take the digit of the lower neighbor
	} cell_ctrl_t;

endpackage

// ----- rtl/i64fmt_cell.sv -----
`timescale 1ns / 1ps
// One BCD digit cell: shift-and-add-3 step and digit hand-over to the neighbor.
module i64fmt_cell (
	input  logic                            clk,
	input  i64fmt_pkg::cell_ctrl_t          ctrl,
	input  logic                            bit_in,
	input  logic [i64fmt_pkg::DIGIT_W-1:0]  digit_in,
	output logic                            bit_out,
	output logic [i64fmt_pkg::DIGIT_W-1:0]  digit
);

	logic [i64fmt_pkg::DIGIT_W-1:0] digit_q;
	logic [i64fmt_pkg::DIGIT_W-1:0] adj;

	// Correct digits of five and above so the doubling carries into the next cell.
	assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign bit_out = adj[i64fmt_pkg::DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.bit_shift) begin
			digit_q <= {adj[i64fmt_pkg::DIGIT_W-2:0], bit_in};
		end else if (ctrl.digit_shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ----- rtl/i64fmt_chain.sv -----
`timescale 1ns / 1ps
// Row of BCD digit cells; binary bits enter at the bottom, digits leave at the top.
module i64fmt_chain (
	input  logic                            clk,
	input  i64fmt_pkg::cell_ctrl_t          ctrl,
	input  logic                            bit_in,
	output logic [i64fmt_pkg::DIGIT_W-1:0]  top_digit
);

	localparam int N = i64fmt_pkg::NUM_DIGITS;

	logic [N:0]                            carry;
	logic [i64fmt_pkg::DIGIT_W-1:0]        digs [N];

	assign carry[0] = bit_in;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [i64fmt_pkg::DIGIT_W-1:0] below;
		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_rest
			assign below = digs[i-1];
		end
		i64fmt_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.bit_in   (carry[i]),
			.digit_in (below),
			.bit_out  (carry[i+1]),
			.digit    (digs[i])
		);
	end

	// The top cell never overflows for magnitudes up to 2^63; its carry is unused.
	assign top_digit = digs[N-1] | {i64fmt_pkg::DIGIT_W{carry[N] & 1'b0}};

endmodule

// ----- rtl/int64_csv_decimal_formatter.sv -----
`timescale 1ns / 1ps
// Top level: signed 64-bit integer to comma-separated decimal ASCII text.
//
// Input stream s_*: one word per value, s_tdata is the two's complement value.
// Output stream m_*: one ASCII byte per word; an optional '-', the digits with
// no leading zeros ('0' for zero), then ',' or a newline. m_tlast marks the
// separator. A newline replaces the comma on every columns_per_row-th value
// (a register of zero counts as one).
// Config: cfg_wr_en/cfg_wr_data write columns_per_row; write it only when idle.
// Sequence: an item is taken in the idle state, then the binary bits run
// through the digit cell row (one bit per cycle), then the skip state shifts
// out leading zero digits, then the output bytes are emitted. A new item is
// accepted only once the previous separator is loaded into the output register.
// A byte waits in the output register while m_tready is low; the sign, digit
// and separator states then hold the digit row and sequencer until the byte
// is taken. Conversion and skip do not stall on the output, and a waiting
// separator does not block the next accept.
// Reset (arst_n low) clears the column counter to zero, sets columns_per_row
// to 5, and drops any pending output word.
module int64_csv_decimal_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] text_byte
	output logic        m_tlast,    // last_byte
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data // columns_per_row
);

	localparam int VW    = i64fmt_pkg::VALUE_W;
	localparam int BCW   = $clog2(VW);
	localparam int DCW   = $clog2(i64fmt_pkg::NUM_DIGITS + 1);
	localparam int CW    = i64fmt_pkg::COL_W;
	localparam logic [BCW-1:0] BIT_LAST   = BCW'(VW - 1);
	localparam logic [DCW-1:0] DIG_START  = DCW'(i64fmt_pkg::NUM_DIGITS);
	localparam logic [DCW-1:0] DIG_ONE    = DCW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGITS,
		ST_SEP
	} state_t;

	state_t                              state_q;
	logic [VW-1:0]                       mag_q;
	logic                                neg_q;
	logic [BCW-1:0]                      bit_cnt_q;
	logic [DCW-1:0]                      dig_left_q;
	logic [CW-1:0]                       cols_q;
	logic [CW-1:0]                       col_pos_q;
	logic                                m_tvalid_q;
	logic [i64fmt_pkg::BYTE_W-1:0]       m_tdata_q;
	logic                                m_tlast_q;

	i64fmt_pkg::cell_ctrl_t              ctrl;
	logic [i64fmt_pkg::DIGIT_W-1:0]      top_digit;
	logic                                accept;
	logic                                out_free;
	logic                                emit;
	logic                                top_zero;
	logic [CW-1:0]                       cols_eff;
	logic [CW:0]                         col_next;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = out_free && ((state_q == ST_SIGN) || (state_q == ST_DIGITS)
	                               || (state_q == ST_SEP));
	assign top_zero = (top_digit == '0);
	assign cols_eff = (cols_q == '0) ? CW'(1) : cols_q;
	assign col_next = {1'b0, col_pos_q} + (CW+1)'(1);

	always_comb begin
		ctrl.clear       = accept;
		ctrl.bit_shift   = (state_q == ST_CONV);
		ctrl.digit_shift = ((state_q == ST_SKIP) && top_zero && (dig_left_q > DIG_ONE))
		                || ((state_q == ST_DIGITS) && out_free);
	end

	i64fmt_chain u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.bit_in    (mag_q[VW-1]),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= i64fmt_pkg::COLS_RESET;
		end else if (cfg_wr_en) begin
			cols_q <= cfg_wr_data;
		end
	end

	// Payload registers: magnitude shifter.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= s_tdata[VW-1] ? (VW'(0) - s_tdata) : s_tdata;
			neg_q <= s_tdata[VW-1];
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= '0;
			dig_left_q <= '0;
			col_pos_q  <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			// load a new word from an emitting state, else drop the held one once taken
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + BCW'(1);
					if (bit_cnt_q == BIT_LAST) begin
						dig_left_q <= DIG_START;
						state_q    <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_zero && (dig_left_q > DIG_ONE)) begin
						dig_left_q <= dig_left_q - DCW'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_DIGITS;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						m_tdata_q  <= i64fmt_pkg::CHAR_MINUS;
						m_tlast_q  <= 1'b0;
						state_q    <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (out_free) begin
						m_tdata_q  <= i64fmt_pkg::CHAR_ZERO
						            + {{(i64fmt_pkg::BYTE_W-i64fmt_pkg::DIGIT_W){1'b0}},
						               top_digit};
						m_tlast_q  <= 1'b0;
						dig_left_q <= dig_left_q - DCW'(1);
						if (dig_left_q == DIG_ONE) begin
							state_q <= ST_SEP;
						end
					end
				end
				ST_SEP: begin
					if (out_free) begin
						m_tlast_q  <= 1'b1;
						if (col_next >= {1'b0, cols_eff}) begin
							m_tdata_q <= i64fmt_pkg::CHAR_LF;
							col_pos_q <= '0;
						end else begin
							m_tdata_q <= i64fmt_pkg::CHAR_COMMA;
							col_pos_q <= col_next[CW-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && (bit_cnt_q == '0))
		else $error("accepted word did not start conversion");

	a_sep_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata == i64fmt_pkg::CHAR_COMMA)
		                     || (m_tdata == i64fmt_pkg::CHAR_LF))
		else $error("last word is not a separator");

	a_no_sep_mid_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata != i64fmt_pkg::CHAR_COMMA)
		                      && (m_tdata != i64fmt_pkg::CHAR_LF))
		else $error("separator inside value text");

	a_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (dig_left_q != '0))
		else $error("digit count ran out");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && (state_q == ST_DIGITS) |=> $stable(dig_left_q))
		else $error("digit emitted while output stalled");

endmodule

// ----- verif/tb_int64_csv_decimal_formatter.sv -----
`timescale 1ns / 1ps
// Testbench for the int64 decimal text formatter: directed table plus random phases.
module tb_int64_csv_decimal_formatter;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 100;
	localparam int NUM_DIR     = 18;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 19;

	typedef struct packed {
		logic [i64fmt_pkg::BYTE_W-1:0] ch;
		logic                          last;
	} text_char_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [63:0]       s_tdata;    // [63:0] value
	logic              m_tvalid;
	logic              m_tready = 1'b1;
	logic [7:0]        m_tdata;    // [7:0] text_byte
	logic              m_tlast;    // last_byte
	logic              cfg_wr_en;
	logic [7:0]        cfg_wr_data;

	text_char_t                    pending_chars[$];
	logic [i64fmt_pkg::COL_W-1:0]  row_length;
	logic [i64fmt_pkg::COL_W-1:0]  row_column;
	int                error_count = 0;
	int                cycle_count = 0;
	int                tx_idle_pct = 0;
	int                rx_stall_pct = 0;

	// Directed values; a non-empty text is the expected text of the value.
	logic [63:0] dir_values[NUM_DIR] = '{
		64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 64'd10, -64'sd10,
		64'd1000000, -64'sd999999, 64'd1000000000000000000,
		-64'sd1000000000000000000, 64'd999999999999999999,
		64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
		64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
		64'hFFFF_FFFF_FFFF_FFFE, 64'd12345678901234567
	};
	string dir_texts[NUM_DIR] = '{
		"0", "1", "-1", "", "", "",
		"1000000", "", "1000000000000000000",
		"", "",
		"9223372036854775807", "-9223372036854775808", "-9223372036854775807",
		"", "",
		"", ""
	};

	int64_csv_decimal_formatter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
	end

	function automatic void note_error(input string what, input logic [7:0] exp_ch,
			input logic exp_last, input logic [7:0] got_ch, input logic got_last);
		error_count++;
		if (error_count <= 10)
			$display("ERROR %s: expected byte %02h last %0b, got byte %02h last %0b",
				what, exp_ch, exp_last, got_ch, got_last);
	endfunction

	// Compare each output word with the oldest expected character.
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				note_error("unexpected word", 8'h00, 1'b0, m_tdata, m_tlast);
			end else begin
				exp_c = pending_chars.pop_front();
				if (m_tdata !== exp_c.ch)
					note_error("text_byte", exp_c.ch, exp_c.last, m_tdata, m_tlast);
				if (m_tlast !== exp_c.last)
					note_error("last_byte", exp_c.ch, exp_c.last, m_tdata, m_tlast);
			end
		end
	end

	// Close the value with a comma, or a newline when it ends the row.
	function automatic void push_separator();
		logic [i64fmt_pkg::COL_W-1:0] cols;
		logic [i64fmt_pkg::COL_W:0]   next_col;
		cols = (row_length == '0) ? i64fmt_pkg::COL_W'(1) : row_length;
		next_col = {1'b0, row_column} + (i64fmt_pkg::COL_W+1)'(1);
		if (next_col >= {1'b0, cols}) begin
			pending_chars.push_back(text_char_t'{ch: i64fmt_pkg::CHAR_LF, last: 1'b1});
			row_column = '0;
		end else begin
			pending_chars.push_back(text_char_t'{ch: i64fmt_pkg::CHAR_COMMA, last: 1'b1});
			row_column = next_col[i64fmt_pkg::COL_W-1:0];
		end
	endfunction

	function automatic void predict_decimal_text(input logic [63:0] v);
		logic [63:0]                   mag;
		logic [i64fmt_pkg::BYTE_W-1:0] digits[$];
		mag = v[63] ? (64'd0 - v) : v;
		do begin
			digits.push_front(i64fmt_pkg::CHAR_ZERO + 8'(mag % 64'd10));
			mag = mag / 64'd10;
		end while (mag != 0);
		if (v[63])
			pending_chars.push_back(text_char_t'{ch: i64fmt_pkg::CHAR_MINUS, last: 1'b0});
		foreach (digits[i])
			pending_chars.push_back(text_char_t'{ch: digits[i], last: 1'b0});
		push_separator();
	endfunction

	function automatic void push_typed_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			pending_chars.push_back(text_char_t'{ch: txt[i], last: 1'b0});
		push_separator();
	endfunction

	// Offer one value; return just after the edge that accepts it.
	task automatic send_value(input logic [63:0] v, input string txt);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata = {$urandom, $urandom};
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = v;
		do @(posedge clk); while (!s_tready);
		if (txt.len() != 0)
			push_typed_text(txt);
		else
			predict_decimal_text(v);
	endtask

	// Drop valid, then hold until every expected byte is out and the block is idle.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_chars.size() != 0) @(negedge clk);
		@(negedge clk);
		while (!s_tready) @(negedge clk);
	endtask

	task automatic write_columns(input logic [7:0] cols);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = cols;
		row_length = cols;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_wr_data = $urandom;
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		logic [63:0] p;
		case ($urandom_range(0, 4))
			0, 1: v = {$urandom, $urandom};
			2: v = 64'($urandom_range(0, 999));
			3: begin
				p = 64'd1;
				repeat ($urandom_range(0, 18)) p = p * 64'd10;
				v = p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: v = {1'b0, 63'($urandom_range(0, 3))} ^
				(($urandom_range(0, 1) != 0) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'd0);
		endcase
		if ($urandom_range(0, 1) != 0)
			v = 64'd0 - v;
		return v;
	endfunction

	initial begin
		logic [7:0] phase_cols[NUM_PHASES];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		row_length = i64fmt_pkg::COLS_RESET;
		row_column = '0;
		phase_cols = '{8'd255, 8'd1, 8'd0, 8'd3, 8'($urandom_range(2, 12)), 8'd7, 8'd2,
			8'($urandom_range(1, 255))};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at the reset row length.
		for (int i = 0; i < NUM_DIR; i++)
			send_value(dir_values[i], dir_texts[i]);
		wait_drained();

		// Raise the row length, then lower it below the current column: next value ends the row.
		write_columns(8'd8);
		repeat (4) send_value(random_value(), "");
		wait_drained();
		write_columns(8'd3);
		repeat (2) send_value(random_value(), "");
		wait_drained();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
				default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
			endcase
			write_columns(phase_cols[ph]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Pause the sender mid-phase until the output has caught up.
				if (ph == 1 && i == PHASE_ITEMS / 2)
					wait_drained();
				send_value(random_value(), "");
			end
			wait_drained();
		end

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
